// ----- rtl/core/scep_pkg.sv -----
// ----------------------------------------------------------------------------
// scep_pkg: shared types and constants for the cubic ease servo profile
// Word layouts, field widths, fixed point format and sequencer states.
// ----------------------------------------------------------------------------
package scep_pkg;

	// Fixed point fraction bits of progress and eased value (Q1.FRAC_BITS).
	localparam int FRAC_BITS = 16;

	localparam int ANGLE_W = 8;
	localparam int DWELL_W = 10;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
	localparam logic [ANGLE_W-1:0] ARM_RESET  = 8'd30;
	localparam logic [ANGLE_W-1:0] TURN_RESET = 8'd100;
	localparam logic [DWELL_W-1:0] MIN_DWELL_RESET = 10'd30;
	localparam logic [DWELL_W-1:0] MAX_DWELL_RESET = 10'd50;

	// Divider: dividend is the step index shifted up by the fraction bits.
	localparam int NUM_W = ANGLE_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	// Shared multiplier operand width covers the eased value and the dwell span.
	localparam int MUL_W  = (FRAC_BITS + 1 > DWELL_W) ? FRAC_BITS + 1 : DWELL_W;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Register word index as decoded from the APB address.
	localparam logic REG_MIN_DWELL = 1'b0;
	localparam logic REG_MAX_DWELL = 1'b1;

	typedef struct packed {
		logic               action;
		logic               servo_select;
		logic [ANGLE_W-1:0] target_angle;
	} req_word_t;

	typedef struct packed {
		logic               valid_res;
		logic               servo_id;
		logic [ANGLE_W-1:0] angle;
		logic [DWELL_W-1:0] dwell_ms;
		logic               last;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQR,
		ST_CUBE,
		ST_OFF,
		ST_DWELL,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/scep_div.sv -----
// ----------------------------------------------------------------------------
// scep_div: radix-2 restoring divider
// Produces one quotient bit per cycle while busy is high.
// ----------------------------------------------------------------------------
module scep_div import scep_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   dividend,
	input  logic [ANGLE_W-1:0] divisor,
	output logic [NUM_W-1:0]   quotient,
	output logic               busy
);

	logic [NUM_W-1:0]   num_q;
	logic [ANGLE_W-1:0] rem_q;
	logic [ANGLE_W-1:0] den_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [ANGLE_W:0]   trial;
	logic [ANGLE_W:0]   diff;
	logic               ge;
	logic [ANGLE_W-1:0] rem_next;

	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign rem_next = ge ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
	assign busy     = (cnt_q != '0);
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The quotient bits shift in from the bottom as the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

endmodule

// ----- rtl/core/scep_mul.sv -----
// ----------------------------------------------------------------------------
// scep_mul: shared unsigned multiplier with a registered product
// Used in turn for the square, the cube, the angle offset and the dwell scale.
// ----------------------------------------------------------------------------
module scep_mul import scep_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// ----- rtl/core/servo_cubic_ease_profile.sv -----
// ----------------------------------------------------------------------------
// servo_cubic_ease_profile: cubic ease-in-out move generator for two servos
// A start word selects a servo and a goal angle; each step word returns the
// next eased angle of the move and the dwell time to wait after it.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Word
//  req       in         req_valid/req_ready   req_word_t (action, servo, goal)
//  rsp       out        rsp_valid/rsp_ready   rsp_word_t (valid, servo, angle,
//                                             dwell, last)
//  apb       in         psel/penable/pready   min_dwell_ms at 0x0, max at 0x4
//
//  A step word during a move runs through the restoring divider, one
//  quotient bit per dividend bit, then the shared multiplier runs four
//  passes in a row and the done state loads the result.
//  A start word, or a step word with no move running, goes straight to the
//  done state, which loads the result; no new word is taken before that.
//  Reset returns the servo angles to 30 and 100, the dwell registers to 30 and
//  50 and drops any move. A stalled rsp only holds the sequencer in its last
//  state; the next req word is accepted in the cycle after the result is
//  loaded.
//
module servo_cubic_ease_profile import scep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_word_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_word_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

	// Configuration registers.
	logic [DWELL_W-1:0] min_dwell_q;
	logic [DWELL_W-1:0] max_dwell_q;

	// Move state, the architectural state of the profile.
	logic [ANGLE_W-1:0] arm_angle_q;
	logic [ANGLE_W-1:0] turn_angle_q;
	logic               moving_q;
	logic [ANGLE_W-1:0] step_idx_q;
	logic [ANGLE_W-1:0] move_start_q;
	logic [ANGLE_W-1:0] move_target_q;
	logic               move_servo_q;

	// Per-step working registers.
	state_t             state_q;
	state_t             state_d;
	logic               res_valid_q;
	logic               up_q;
	logic               last_q;
	logic [ANGLE_W-1:0] range_q;
	logic [FRAC_BITS-1:0] x_q;
	logic               lt_q;
	logic [FRAC_BITS:0] e_q;
	logic [ANGLE_W-1:0] off_q;

	// Result register.
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	// Control and datapath nets.
	logic               accept;
	logic               is_step;
	logic               div_start;
	logic               div_busy;
	logic [NUM_W-1:0]   div_quo;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;
	logic               rsp_load;

	logic               cfg_wr;
	logic [ANGLE_W-1:0] goal_sat;
	logic               up_c;
	logic [ANGLE_W-1:0] range_c;
	logic [ANGLE_W-1:0] idx_c;
	logic               fin_c;

	logic [FRAC_BITS:0]   p_c;
	logic                 lt_c;
	logic [FRAC_BITS:0]   q_c;
	logic [FRAC_BITS-1:0] x_c;
	logic [FRAC_BITS-1:0] t_c;
	logic [FRAC_BITS:0]   e_c;
	logic                 dwell_dn;
	logic [DWELL_W-1:0]   span;
	logic [DWELL_W-1:0]   dw_off;
	rsp_word_t            res_c;

	// ---------------------------------------------------------------------
	// Configuration port. Only the word index (address bit 2) is decoded.
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dwell_q <= MIN_DWELL_RESET;
			max_dwell_q <= MAX_DWELL_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MIN_DWELL: min_dwell_q <= pwdata[DWELL_W-1:0];
				REG_MAX_DWELL: max_dwell_q <= pwdata[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_DWELL: prdata = {(32 - DWELL_W)'(0), min_dwell_q};
			REG_MAX_DWELL: prdata = {(32 - DWELL_W)'(0), max_dwell_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Word intake. A step word is clamped to the move's range here, and the
	// move state is advanced at once; the sequencer only needs the latched
	// index, range and direction to produce the result.
	// ---------------------------------------------------------------------
	assign accept   = req_valid && req_ready;
	assign is_step  = (req.action == ACT_STEP);
	assign goal_sat = (req.target_angle > ANGLE_MAX) ? ANGLE_MAX : req.target_angle;

	assign up_c    = move_start_q < move_target_q;
	assign range_c = up_c ? move_target_q - move_start_q : move_start_q - move_target_q;
	assign idx_c   = (step_idx_q > range_c) ? range_c : step_idx_q;
	assign fin_c   = (idx_c >= range_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_angle_q   <= ARM_RESET;
			turn_angle_q  <= TURN_RESET;
			moving_q      <= 1'b0;
			step_idx_q    <= '0;
			move_start_q  <= '0;
			move_target_q <= '0;
			move_servo_q  <= 1'b0;
		end else if (accept) begin
			if (!is_step) begin
				// A start replaces any running move and begins at the stored angle.
				move_servo_q  <= req.servo_select;
				move_start_q  <= req.servo_select ? turn_angle_q : arm_angle_q;
				move_target_q <= goal_sat;
				step_idx_q    <= '0;
				moving_q      <= 1'b1;
			end else if (moving_q) begin
				if (fin_c) begin
					if (move_servo_q) begin
						turn_angle_q <= move_target_q;
					end else begin
						arm_angle_q <= move_target_q;
					end
					moving_q   <= 1'b0;
					step_idx_q <= '0;
				end else begin
					step_idx_q <= idx_c + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared units.
	// ---------------------------------------------------------------------
	scep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({idx_c, FRAC_BITS'(0)}),
		.divisor  (range_c),
		.quotient (div_quo),
		.busy     (div_busy)
	);

	scep_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// ---------------------------------------------------------------------
	// Easing datapath. Progress p is forced to zero for a zero-length move.
	// Below one half the cube is taken of p, otherwise of 1 - p and then
	// mirrored. The factor four folds into the shift of the cube.
	// ---------------------------------------------------------------------
	assign p_c  = (range_q == '0) ? '0 : div_quo[FRAC_BITS:0];
	assign lt_c = p_c < HALF;
	assign q_c  = ONE - p_c;
	assign x_c  = lt_c ? p_c[FRAC_BITS-1:0] : q_c[FRAC_BITS-1:0];
	assign t_c  = prod[FRAC_BITS-2 +: FRAC_BITS];
	assign e_c  = lt_q ? {1'b0, t_c} : ONE - {1'b0, t_c};

	assign dwell_dn = max_dwell_q < min_dwell_q;
	assign span     = dwell_dn ? min_dwell_q - max_dwell_q : max_dwell_q - min_dwell_q;
	assign dw_off   = prod[FRAC_BITS +: DWELL_W];

	always_comb begin
		res_c           = '0;
		if (res_valid_q) begin
			res_c.valid_res = 1'b1;
			res_c.servo_id  = move_servo_q;
			res_c.angle     = up_q ? move_start_q + off_q : move_start_q - off_q;
			res_c.dwell_ms  = dwell_dn ? min_dwell_q - dw_off : min_dwell_q + dw_off;
			res_c.last      = last_q;
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: next state.
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (is_step && moving_q) ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR:   state_d = ST_CUBE;
			ST_CUBE:  state_d = ST_OFF;
			ST_OFF:   state_d = ST_DWELL;
			ST_DWELL: state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: outputs. The multiplier is fed x*x, s*x, e*range and then
	// e*span; the last pair is held in the done state so that the product
	// stays put while the result waits for space.
	// ---------------------------------------------------------------------
	always_comb begin
		req_ready = 1'b0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				div_start = req_valid && is_step && moving_q;
			end
			ST_DIV: ;
			ST_SQR: begin
				mul_a = MUL_W'(x_c);
				mul_b = MUL_W'(x_c);
			end
			ST_CUBE: begin
				mul_a = MUL_W'(prod[FRAC_BITS +: FRAC_BITS]);
				mul_b = MUL_W'(x_q);
			end
			ST_OFF: begin
				mul_a = MUL_W'(e_c);
				mul_b = MUL_W'(range_q);
			end
			ST_DWELL: begin
				mul_a = MUL_W'(e_q);
				mul_b = MUL_W'(span);
			end
			ST_DONE: begin
				mul_a    = MUL_W'(e_q);
				mul_b    = MUL_W'(span);
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				res_valid_q <= is_step && moving_q;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_q    <= up_c;
			last_q  <= fin_c;
			range_q <= range_c;
		end
		if (state_q == ST_SQR) begin
			x_q  <= x_c;
			lt_q <= lt_c;
		end
		if (state_q == ST_OFF) begin
			e_q <= e_c;
		end
		if (state_q == ST_DWELL) begin
			off_q <= prod[FRAC_BITS +: ANGLE_W];
		end
		if (rsp_load) begin
			rsp_q <= res_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------
	a_idle_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> step_idx_q == '0)
		else $error("step index not cleared while no move runs");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQR |-> !div_busy)
		else $error("easing started before the divider finished");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.angle <= ANGLE_MAX)
		else $error("result angle beyond the servo range");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> rsp.valid_res)
		else $error("last flag on a result without a step");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for servo_cubic_ease_profile
// Sends start and step words through a clocked driver and checks every
// response word against an in-bench fixed point predictor. The driver and
// the response monitor stall and idle at random.
// ----------------------------------------------------------------------------
module tb import scep_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_word_t         req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_word_t         rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Words waiting to be offered, and the step results predicted for
	// words the block has already taken, oldest first.
	req_word_t         queued_cmds[$];
	rsp_word_t         predicted_steps[$];

	// Predictor copy of the block state and its dwell registers.
	logic [ANGLE_W-1:0] arm_deg = ARM_RESET;
	logic [ANGLE_W-1:0] turn_deg = TURN_RESET;
	logic               mv_active = 1'b0;
	logic [ANGLE_W-1:0] mv_idx = '0;
	logic [ANGLE_W-1:0] mv_from = '0;
	logic [ANGLE_W-1:0] mv_to = '0;
	logic               mv_servo = 1'b0;
	logic [DWELL_W-1:0] dw_min = MIN_DWELL_RESET;
	logic [DWELL_W-1:0] dw_max = MAX_DWELL_RESET;

	// Generator's own view of where each servo will be once the queued
	// words have played out, so that it can build complete moves.
	int                 gen_arm = 0;
	int                 gen_turn = 0;
	logic               gen_moving = 1'b0;

	// When low, neither side idles at random between words.
	logic               idle_on = 1'b1;

	int                 req_gap = 0;
	int                 rsp_hold = 0;
	int                 n_accepted = 0;
	int                 n_checked = 0;
	int                 n_last = 0;
	int                 n_cfg = 0;
	int                 n_fail = 0;

	servo_cubic_ease_profile uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	// Prints one line per mismatch (the first few dozen) and counts them all.
	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		n_fail++;
		if (n_fail <= 40) begin
			$display("mismatch: %s after %0d results, expected %0d, got %0d",
			         what, n_checked, want, got);
		end
	endtask

	// Works out the response word to one accepted request word and advances
	// the predicted state. Progress and easing are Q1.FRAC_BITS and every
	// product is floored, exactly as the hardware is meant to do it.
	function automatic rsp_word_t ease_next_step(req_word_t w);
		rsp_word_t          r;
		logic [ANGLE_W-1:0] goal;
		int unsigned        span;
		int unsigned        idx;
		longint unsigned    one;
		longint unsigned    p;
		longint unsigned    q;
		longint unsigned    s;
		longint unsigned    e;
		longint unsigned    off;
		logic               rising;
		logic               fin;
		r = '0;
		one = 64'd1 << FRAC_BITS;
		if (w.action == ACT_START) begin
			// A start word always answers with an empty word. A goal past the
			// end of travel is clamped, and the move always begins from the
			// stored angle, even when it replaces a move still running.
			goal = (w.target_angle > ANGLE_MAX) ? ANGLE_MAX : w.target_angle;
			mv_servo = w.servo_select;
			mv_from = w.servo_select ? turn_deg : arm_deg;
			mv_to = goal;
			mv_idx = '0;
			mv_active = 1'b1;
			return r;
		end
		// A step with no move running also answers with an empty word.
		if (!mv_active) begin
			return r;
		end
		rising = mv_from < mv_to;
		span = rising ? mv_to - mv_from : mv_from - mv_to;
		idx = (mv_idx > span) ? span : mv_idx;
		// A zero-length move is a single step at zero eased progress.
		if (span == 0) begin
			e = 0;
		end else begin
			p = (64'(idx) << FRAC_BITS) / span;
			if (p < (one >> 1)) begin
				s = (p * p) >> FRAC_BITS;
				e = (4 * s * p) >> FRAC_BITS;
			end else begin
				q = (p >= one) ? 64'd0 : one - p;
				s = (q * q) >> FRAC_BITS;
				e = one - ((4 * s * q) >> FRAC_BITS);
			end
		end
		off = (e * span) >> FRAC_BITS;
		r.valid_res = 1'b1;
		r.servo_id = mv_servo;
		r.angle = rising ? mv_from + off[ANGLE_W-1:0] : mv_from - off[ANGLE_W-1:0];
		// The dwell moves toward max_dwell_ms from either side, truncating
		// toward min_dwell_ms.
		if (dw_max >= dw_min) begin
			r.dwell_ms = dw_min + DWELL_W'((e * (dw_max - dw_min)) >> FRAC_BITS);
		end else begin
			r.dwell_ms = dw_min - DWELL_W'((e * (dw_min - dw_max)) >> FRAC_BITS);
		end
		fin = idx >= span;
		r.last = fin;
		if (fin) begin
			if (mv_servo) begin
				turn_deg = mv_to;
			end else begin
				arm_deg = mv_to;
			end
			mv_active = 1'b0;
			mv_idx = '0;
		end else begin
			mv_idx = ANGLE_W'(idx + 1);
		end
		return r;
	endfunction

	task automatic queue_cmd(logic act, logic sel, logic [ANGLE_W-1:0] goal);
		req_word_t w;
		w.action = act;
		w.servo_select = sel;
		w.target_angle = goal;
		queued_cmds.push_back(w);
	endtask

	// A step word carries junk in the fields it does not use.
	task automatic queue_step();
		queue_cmd(ACT_STEP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	// Builds random moves until about n words are queued. Most moves are
	// complete, run from the stored angle to a goal close by; some have a goal
	// anywhere (long moves, clamped goals), some are cut short by the next
	// start, and a few stray steps land while no move runs.
	task automatic queue_random_moves(int n);
		int   cnt;
		int   roll;
		int   cur;
		int   goal;
		int   eff;
		int   span;
		int   steps;
		logic sel;
		cnt = 0;
		while (cnt < n) begin
			roll = $urandom_range(0, 99);
			if (roll < 6 && !gen_moving) begin
				queue_step();
				cnt++;
			end else begin
				sel = 1'($urandom_range(0, 1));
				cur = sel ? gen_turn : gen_arm;
				if (roll < 18) begin
					goal = $urandom_range(0, 255);
				end else begin
					goal = cur + $urandom_range(0, 24) - 12;
					if (goal < 0) begin
						goal = 0;
					end
					if (goal > ANGLE_MAX) begin
						goal = ANGLE_MAX;
					end
				end
				eff = (goal > ANGLE_MAX) ? ANGLE_MAX : goal;
				span = (eff > cur) ? eff - cur : cur - eff;
				queue_cmd(ACT_START, sel, 8'(goal));
				if (roll >= 90) begin
					steps = $urandom_range(0, span);
					gen_moving = 1'b1;
				end else begin
					steps = span + 1;
					gen_moving = 1'b0;
					if (sel) begin
						gen_turn = eff;
					end else begin
						gen_arm = eff;
					end
				end
				repeat (steps) queue_step();
				cnt += steps + 1;
			end
		end
	endtask

	// Writes one dwell register, with junk in the unused upper bits, and
	// reads it straight back over the same port.
	task automatic set_dwell_reg(logic sel, logic [DWELL_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {22'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		// The write lands on this edge; go straight into a read setup.
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_MIN_DWELL) begin
			dw_min = value;
		end else begin
			dw_max = value;
		end
		n_cfg++;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {22'd0, value}) begin
			flag_mismatch("register read back", value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Waits until every queued word has been taken and every predicted
	// result has come back, then lets the sequencer settle.
	task automatic drain();
		int waited;
		waited = 0;
		while ((queued_cmds.size() != 0 || req_valid || predicted_steps.size() != 0)
		       && waited < 50000) begin
			@(negedge clk);
			waited++;
		end
		repeat (40) @(negedge clk);
	endtask

	// Request driver: offers the oldest queued word, holds it until taken,
	// and predicts its result at the edge where it is accepted. Between
	// words it idles for a randomly drawn number of cycles while idle_on is high.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				predicted_steps.push_back(ease_next_step(req));
				n_accepted++;
			end
			if (!req_valid || req_ready) begin
				if (req_gap != 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (queued_cmds.size() != 0) begin
					req <= queued_cmds.pop_front();
					req_valid <= 1'b1;
					req_gap = idle_on ? $urandom_range(0, 8) : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: checks each accepted word field by field against the
	// oldest prediction. After each word, with idle_on high, it drops ready for a random count
	// of cycles; twice in the run it holds off for a long stretch so that
	// the block backs up and stops taking requests.
	always @(posedge clk) begin : rsp_side
		rsp_word_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_hold = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_steps.size() == 0) begin
					flag_mismatch("result with nothing outstanding", 0, rsp);
				end else begin
					want = predicted_steps.pop_front();
					if (rsp.valid_res !== want.valid_res) begin
						flag_mismatch("valid_res", want.valid_res, rsp.valid_res);
					end
					if (rsp.servo_id !== want.servo_id) begin
						flag_mismatch("servo_id", want.servo_id, rsp.servo_id);
					end
					if (rsp.angle !== want.angle) begin
						flag_mismatch("angle", want.angle, rsp.angle);
					end
					if (rsp.dwell_ms !== want.dwell_ms) begin
						flag_mismatch("dwell_ms", want.dwell_ms, rsp.dwell_ms);
					end
					if (rsp.last !== want.last) begin
						flag_mismatch("last", want.last, rsp.last);
					end
				end
				n_checked++;
				if (rsp.last === 1'b1) begin
					n_last++;
				end
				if (n_checked == 200 || n_checked == 800) begin
					rsp_hold = 300;
				end else begin
					rsp_hold = idle_on ? $urandom_range(0, 8) : 0;
				end
			end else if (rsp_hold != 0) begin
				rsp_hold--;
			end
			rsp_ready <= (rsp_hold == 0);
		end
	end

	// Run guard: a correct run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [DWELL_W-1:0] set_min[6];
		logic [DWELL_W-1:0] set_max[6];
		set_min = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0};
		set_max = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0};
		set_min[4] = 10'($urandom);
		set_max[4] = 10'($urandom);
		set_min[5] = 10'($urandom);
		set_max[5] = 10'($urandom);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset dwell settings.
		queue_step();                           // step with no move running
		queue_cmd(ACT_START, 1'b0, 8'd30);      // zero-length move
		queue_step();
		queue_step();                           // idle again after last
		queue_cmd(ACT_START, 1'b0, 8'd33);      // short move up
		repeat (4) queue_step();
		queue_cmd(ACT_START, 1'b0, 8'd30);      // short move down
		repeat (4) queue_step();
		queue_cmd(ACT_START, 1'b1, 8'd255);     // goal clamped to end of travel
		repeat (2) queue_step();
		queue_cmd(ACT_START, 1'b1, 8'd98);      // replaces the running move
		repeat (3) queue_step();
		queue_cmd(ACT_START, 1'b0, 8'd0);
		queue_step();
		queue_cmd(ACT_START, 1'b0, ANGLE_MAX);  // left running into the next part
		queue_step();
		gen_arm = 30;
		gen_turn = 98;
		gen_moving = 1'b1;
		drain();

		// Random part: one batch per dwell setting, extremes first. Two of
		// the batches run with no idling on either side.
		for (int ph = 0; ph < 6; ph++) begin
			set_dwell_reg(REG_MIN_DWELL, set_min[ph]);
			set_dwell_reg(REG_MAX_DWELL, set_max[ph]);
			idle_on = (ph != 2 && ph != 5);
			@(negedge clk);
			queue_random_moves(222);
			drain();
		end

		if (predicted_steps.size() != 0) begin
			flag_mismatch("results never returned", 0, predicted_steps.size());
		end
		$display("Sent %0d request words, checked %0d response words, %0d moves ran to the end.",
		         n_accepted, n_checked, n_last);
		$display("Dwell registers were set %0d times, across both extremes and random values.",
		         n_cfg);
		if (n_fail == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
